FILE: rtl/fsmf_pkg.sv
// Shared types and constants for the first substring match finder.
// Used by every module in this folder; depends on nothing.
package fsmf_pkg;

	localparam int HAY_W        = 8;
	localparam int LEN_W        = 5;
	localparam int NEEDLE_IDX_W = 4;
	localparam int NEEDLE_SLOTS = 1 << NEEDLE_IDX_W;
	localparam int POS_OUT_W    = 16;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_IDX_W    = 2;
	localparam int OUT_DATA_W   = 24;
	localparam int QUEUE_AW     = 2;
	localparam int QUEUE_DEPTH  = 1 << QUEUE_AW;

	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH   = 2'd2;

	typedef struct packed {
		logic             is_last;
		logic [HAY_W-1:0] hay_byte;
	} item_t;

endpackage

FILE: rtl/fsmf_cfg.sv
// Configuration registers and the needle lined up by window age.
// Depends on fsmf_pkg.
module fsmf_cfg #(
	parameter int MAX_NEEDLE = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [fsmf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fsmf_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic [fsmf_pkg::LEN_W-1:0]             len_used,
	output logic [MAX_NEEDLE-1:0][fsmf_pkg::HAY_W-1:0] needle_aligned,
	output logic [MAX_NEEDLE-1:0]                  needle_mask
);
	import fsmf_pkg::*;

	logic [LEN_W-1:0]      length_q;
	logic [CFG_DATA_W-1:0] low_q;
	logic [CFG_DATA_W-1:0] high_q;

	logic [NEEDLE_SLOTS-1:0][HAY_W-1:0] bytes_c;
	logic [LEN_W-1:0]                   len_c;
	logic [MAX_NEEDLE-1:0][HAY_W-1:0]   aligned_c;
	logic [MAX_NEEDLE-1:0]              mask_c;

	logic [LEN_W-1:0]                   len_used_q;
	logic [MAX_NEEDLE-1:0][HAY_W-1:0]   aligned_q;
	logic [MAX_NEEDLE-1:0]              mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			low_q    <= '0;
			high_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEEDLE_LENGTH: length_q <= cfg_data[LEN_W-1:0];
				REG_NEEDLE_LOW:    low_q    <= cfg_data;
				REG_NEEDLE_HIGH:   high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Age a of the window is compared with needle byte len - 1 - a.
	always_comb begin
		logic [LEN_W-1:0] idx;
		bytes_c = {high_q, low_q};
		len_c   = (length_q > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : length_q;
		for (int a = 0; a < MAX_NEEDLE; a++) begin
			idx          = len_c - LEN_W'(a) - LEN_W'(1);
			mask_c[a]    = LEN_W'(a) < len_c;
			aligned_c[a] = bytes_c[idx[NEEDLE_IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_used_q <= '0;
			mask_q     <= '0;
		end else begin
			len_used_q <= len_c;
			mask_q     <= mask_c;
		end
	end

	always_ff @(posedge clk) begin
		aligned_q <= aligned_c;
	end

	assign len_used       = len_used_q;
	assign needle_aligned = aligned_q;
	assign needle_mask    = mask_q;

endmodule

FILE: rtl/fsmf_front.sv
// Input side: accepts haystack bytes and queues them for the search stage.
// Depends on fsmf_pkg.
module fsmf_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [fsmf_pkg::HAY_W-1:0] s_tdata,
	input  logic                      s_tlast,
	output logic                      q_valid,
	output fsmf_pkg::item_t           q_item,
	input  logic                      q_pop
);
	import fsmf_pkg::*;

	item_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                push;

	assign s_tready = count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = count_q != '0;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{is_last: s_tlast, hay_byte: s_tdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + (QUEUE_AW + 1)'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - (QUEUE_AW + 1)'(1);
			end
		end
	end

endmodule

FILE: rtl/fsmf_back.sv
// Search stage: byte window, position counter, needle compare, result register.
// Depends on fsmf_pkg.
module fsmf_back #(
	parameter int MAX_NEEDLE     = 16,
	parameter int POSITION_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_valid,
	input  fsmf_pkg::item_t                        q_item,
	output logic                                   q_pop,
	input  logic [fsmf_pkg::LEN_W-1:0]             len_used,
	input  logic [MAX_NEEDLE-1:0][fsmf_pkg::HAY_W-1:0] needle_aligned,
	input  logic [MAX_NEEDLE-1:0]                  needle_mask,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [fsmf_pkg::OUT_DATA_W-1:0]        m_tdata
);
	import fsmf_pkg::*;

	localparam int SEEN_W = POSITION_WIDTH + 1;

	logic [MAX_NEEDLE-1:0][HAY_W-1:0] win_q;
	logic [SEEN_W-1:0]                seen_q;
	logic                             match_q;
	logic [POSITION_WIDTH-1:0]        first_q;
	logic                             out_valid_q;
	logic                             out_found_q;
	logic [POS_OUT_W-1:0]             out_pos_q;

	logic [MAX_NEEDLE-1:0][HAY_W-1:0] win_c;
	logic [SEEN_W-1:0]                seen_c;
	logic [SEEN_W-1:0]                start_c;
	logic                             win_match;
	logic                             hit;
	logic                             len_zero;
	logic [POSITION_WIDTH-1:0]        pos_c;
	logic [POSITION_WIDTH+POS_OUT_W-1:0] pos_ext;

	assign q_pop = q_valid && (!q_item.is_last || !out_valid_q || m_tready);

	always_comb begin
		win_c[0] = q_item.hay_byte;
		for (int a = 1; a < MAX_NEEDLE; a++) begin
			win_c[a] = win_q[a-1];
		end
		win_match = 1'b1;
		for (int a = 0; a < MAX_NEEDLE; a++) begin
			if (needle_mask[a] && (win_c[a] != needle_aligned[a])) begin
				win_match = 1'b0;
			end
		end
	end

	assign len_zero = len_used == '0;
	assign seen_c   = (&seen_q) ? seen_q : seen_q + SEEN_W'(1);
	assign start_c  = seen_c - SEEN_W'(len_used);
	assign hit      = !len_zero && !match_q && (seen_c >= SEEN_W'(len_used))
	                  && !start_c[POSITION_WIDTH] && win_match;
	assign pos_c    = len_zero ? '0 :
	                  match_q  ? first_q :
	                  hit      ? start_c[POSITION_WIDTH-1:0] : '0;
	assign pos_ext  = {{POS_OUT_W{1'b0}}, pos_c};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			win_q <= win_c;
		end
		if (q_pop && hit) begin
			first_q <= start_c[POSITION_WIDTH-1:0];
		end
		if (q_pop && q_item.is_last) begin
			out_found_q <= len_zero || match_q || hit;
			out_pos_q   <= pos_ext[POS_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			match_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.is_last) begin
					seen_q  <= '0;
					match_q <= 1'b0;
				end else begin
					seen_q  <= seen_c;
					match_q <= match_q || hit;
				end
			end
			if (q_pop && q_item.is_last) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - POS_OUT_W - 1){1'b0}}, out_pos_q, out_found_q};

endmodule

FILE: rtl/first_substring_match_finder.sv
// Top level of the first substring match finder.
// Depends on fsmf_pkg, fsmf_cfg, fsmf_front and fsmf_back.
//
// Channel  Direction  Handshake          Content
// s        in         s_tvalid/s_tready  one haystack byte, s_tlast marks the last
// m        out        m_tvalid/m_tready  one result per haystack
// cfg      in         cfg_we             needle length and needle bytes
//
// One byte is taken per cycle while the input queue has room; the search stage also
// handles one byte per cycle but for the stall below. Each accepted byte waits in the
// four-entry input queue, and the search stage registers the result of a haystack
// on the edge at which it takes the last byte from that queue.
// Reset clears the configuration, the queue and the search state at once.
// A stalled result holds the search stage only when the next last byte arrives;
// the input queue keeps accepting until it is full.
module first_substring_match_finder #(
	parameter int MAX_NEEDLE     = 16,
	parameter int POSITION_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [fsmf_pkg::HAY_W-1:0]       s_tdata,  // [7:0] hay_byte
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fsmf_pkg::OUT_DATA_W-1:0]  m_tdata,  // [0] found, [16:1] match_position
	input  logic                             cfg_we,
	input  logic [fsmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fsmf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fsmf_pkg::*;

	logic                             q_valid;
	item_t                            q_item;
	logic                             q_pop;
	logic [LEN_W-1:0]                 len_used;
	logic [MAX_NEEDLE-1:0][HAY_W-1:0] needle_aligned;
	logic [MAX_NEEDLE-1:0]            needle_mask;

	fsmf_cfg #(
		.MAX_NEEDLE(MAX_NEEDLE)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.len_used      (len_used),
		.needle_aligned(needle_aligned),
		.needle_mask   (needle_mask)
	);

	fsmf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	fsmf_back #(
		.MAX_NEEDLE    (MAX_NEEDLE),
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.len_used      (len_used),
		.needle_aligned(needle_aligned),
		.needle_mask   (needle_mask),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata)
	);

endmodule
